// ----- rtl/core/kvfs_pkg.sv -----
// Shared types and constants for the key/value field splitter.
// Used by every module in rtl/core; depends on nothing.
package kvfs_pkg;

	localparam int unsigned MAX_KEY   = 64;
	localparam int unsigned MAX_VALUE = 256;

	localparam int unsigned KEY_W  = 9;
	localparam int unsigned VAL_W  = 13;
	localparam int unsigned CHAR_W = 8;

	localparam logic [KEY_W-1:0] KEY_SAT   = '1;
	localparam logic [VAL_W-1:0] VAL_SAT   = '1;
	localparam logic [KEY_W-1:0] KEY_LIMIT = KEY_W'(MAX_KEY - 1);
	localparam logic [VAL_W-1:0] VAL_LIMIT = VAL_W'(MAX_VALUE - 1);

	localparam logic [KEY_W-1:0] KEY_SIZE_RST = KEY_W'(64);
	localparam logic [VAL_W-1:0] VAL_SIZE_RST = VAL_W'(256);

	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0a;

	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_CMD      = 3'd0,
		PH_KEY      = 3'd1,
		PH_GAP      = 3'd2,
		PH_QUOTED   = 3'd3,
		PH_UNQUOTED = 3'd4,
		PH_CLOSED   = 3'd5
	} kvfs_phase_t;

	typedef enum logic [1:0] {
		ITEM_KEY    = 2'd0,
		ITEM_VALUE  = 2'd1,
		ITEM_STATUS = 2'd2
	} kvfs_item_type_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_PARSE_ERR = 2'd1,
		ST_KEY_LONG  = 2'd2,
		ST_VAL_LONG  = 2'd3
	} kvfs_status_t;

	typedef enum logic [0:0] {
		REG_KEY_SIZE = 1'b0,
		REG_VAL_SIZE = 1'b1
	} kvfs_reg_t;

	typedef struct packed {
		logic [1:0]        item_type;
		logic [CHAR_W-1:0] ch;
		logic [1:0]        status;
		logic              final_res;
	} kvfs_item_t;

	typedef struct packed {
		logic [1:0] count;
		kvfs_item_t item0;
		kvfs_item_t item1;
	} kvfs_push_t;

endpackage

// ----- rtl/core/kvfs_parse.sv -----
// Phase machine and counters that split one registered byte into result requests.
// Depends on kvfs_pkg.
module kvfs_parse (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_s1,
	input  logic [kvfs_pkg::CHAR_W-1:0]  char_s1,
	input  logic                         eol_s1,
	input  logic [kvfs_pkg::KEY_W-1:0]   key_cap,
	input  logic [kvfs_pkg::VAL_W-1:0]   val_size,
	output kvfs_pkg::kvfs_push_t         push
);
	import kvfs_pkg::*;

	kvfs_phase_t       phase_q, phase_d;
	logic [KEY_W-1:0]  key_cnt_q, key_cnt_d;
	logic [VAL_W-1:0]  val_cnt_q, val_cnt_d;
	logic              nl_q, nl_d;
	logic              kovf_q, kovf_d;
	logic              emit;
	logic [1:0]        byte_type;
	logic [1:0]        st;
	logic [VAL_W-1:0]  len;
	kvfs_item_t        byte_item, st_item;

	always_comb begin
		phase_d   = phase_q;
		key_cnt_d = key_cnt_q;
		val_cnt_d = val_cnt_q;
		nl_d      = nl_q;
		kovf_d    = kovf_q;
		unique case (phase_q)
			PH_CMD: begin
				if (char_s1 == CH_SPACE) phase_d = PH_KEY;
			end
			PH_KEY: begin
				if (char_s1 == CH_SPACE) begin
					kovf_d  = (key_cnt_q >= key_cap) || (key_cnt_q >= KEY_LIMIT);
					phase_d = PH_GAP;
				end else if (key_cnt_q != KEY_SAT) begin
					key_cnt_d = key_cnt_q + KEY_W'(1);
				end
			end
			PH_GAP: begin
				if (char_s1 == CH_QUOTE) begin
					phase_d = PH_QUOTED;
				end else if (char_s1 != CH_SPACE) begin
					phase_d   = PH_UNQUOTED;
					val_cnt_d = VAL_W'(1);
					if (char_s1 == CH_NEWLINE) nl_d = 1'b1;
				end
			end
			PH_QUOTED: begin
				if (char_s1 == CH_QUOTE) begin
					phase_d = PH_CLOSED;
				end else if (val_cnt_q != VAL_SAT) begin
					val_cnt_d = val_cnt_q + VAL_W'(1);
				end
			end
			PH_UNQUOTED: begin
				if (val_cnt_q != VAL_SAT) val_cnt_d = val_cnt_q + VAL_W'(1);
				if (char_s1 == CH_NEWLINE) nl_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		byte_type = ITEM_VALUE;
		unique case (phase_q)
			PH_KEY: begin
				emit      = (char_s1 != CH_SPACE);
				byte_type = ITEM_KEY;
			end
			PH_GAP:      emit = (char_s1 != CH_SPACE) && (char_s1 != CH_QUOTE) &&
			                    (char_s1 != CH_NEWLINE);
			PH_QUOTED:   emit = (char_s1 != CH_QUOTE);
			PH_UNQUOTED: emit = !nl_q && (char_s1 != CH_NEWLINE);
			default:     emit = 1'b0;
		endcase

		len = (val_cnt_d < val_size) ? val_cnt_d : val_size;
		if (phase_d == PH_CMD || phase_d == PH_KEY) begin
			st = ST_PARSE_ERR;
		end else if (kovf_d) begin
			st = ST_KEY_LONG;
		end else if (phase_d == PH_GAP || phase_d == PH_QUOTED) begin
			st = ST_PARSE_ERR;
		end else if (phase_d == PH_CLOSED) begin
			st = ((val_cnt_d >= val_size) || (val_cnt_d >= VAL_LIMIT)) ? ST_VAL_LONG : ST_OK;
		end else begin
			st = (((val_size != '0) && (len >= val_size - VAL_W'(1))) || (len >= VAL_LIMIT))
			     ? ST_VAL_LONG : ST_OK;
		end

		byte_item = '{item_type: byte_type, ch: char_s1, status: ST_OK, final_res: 1'b0};
		st_item   = '{item_type: ITEM_STATUS, ch: '0, status: st, final_res: 1'b1};

		push.item0 = emit ? byte_item : st_item;
		push.item1 = st_item;
		if (!valid_s1) push.count = 2'd0;
		else           push.count = 2'({1'b0, emit} + {1'b0, eol_s1});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_CMD;
			key_cnt_q <= '0;
			val_cnt_q <= '0;
			nl_q      <= 1'b0;
			kovf_q    <= 1'b0;
		end else if (valid_s1) begin
			if (eol_s1) begin
				phase_q   <= PH_CMD;
				key_cnt_q <= '0;
				val_cnt_q <= '0;
				nl_q      <= 1'b0;
				kovf_q    <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				key_cnt_q <= key_cnt_d;
				val_cnt_q <= val_cnt_d;
				nl_q      <= nl_d;
				kovf_q    <= kovf_d;
			end
		end
	end

endmodule

// ----- rtl/core/kvfs_res_fifo.sv -----
// Result queue that takes up to two requests per cycle and hands out one.
// Depends on kvfs_pkg.
module kvfs_res_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  kvfs_pkg::kvfs_push_t         push,
	input  logic                         pop,
	output logic                         not_empty,
	output logic [kvfs_pkg::FIFO_CW-1:0] count,
	output kvfs_pkg::kvfs_item_t         head
);
	import kvfs_pkg::*;

	kvfs_item_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q;
	logic [FIFO_AW-1:0]  rd_ptr_q;
	logic [FIFO_CW-1:0]  count_q;
	logic [FIFO_AW-1:0]  wr_ptr_1;

	assign wr_ptr_1  = wr_ptr_q + FIFO_AW'(1);
	assign not_empty = (count_q != '0);
	assign count     = count_q;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem_q[wr_ptr_q] <= push.item0;
		if (push.count == 2'd2) mem_q[wr_ptr_1] <= push.item1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.count);
			if (pop) rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			count_q <= count_q + FIFO_CW'(push.count) - FIFO_CW'(pop);
		end
	end

endmodule

// ----- rtl/core/key_value_field_splitter.sv -----
// Top level of the key/value field splitter: input register, parser and result queue.
// Depends on kvfs_pkg, kvfs_parse and kvfs_res_fifo.
// With an empty result queue, a byte's results pass the input register and then are
// written to the queue together; the second is presented once the first is popped.
// Throughput: one byte per cycle; the input stalls only while the eight-entry result
// queue lacks room for two more results per byte in flight.
// Reset clears the phase machine, counters and queue, and loads the size registers.
module key_value_field_splitter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [kvfs_pkg::CHAR_W-1:0] char_in,
	input  logic                        end_of_line,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  item_type,
	output logic [kvfs_pkg::CHAR_W-1:0] char_out,
	output logic [1:0]                  status,
	output logic                        final_res,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [0:0]                  cfg_index,
	input  logic [kvfs_pkg::VAL_W-1:0]  cfg_data
);
	import kvfs_pkg::*;

	logic               valid_s1;
	logic [CHAR_W-1:0]  char_s1;
	logic               eol_s1;
	logic [KEY_W-1:0]   key_cap_q;
	logic [VAL_W-1:0]   val_size_q;
	kvfs_push_t         push;
	kvfs_item_t         head;
	logic [FIFO_CW-1:0] fifo_count;
	logic               pop;

	assign cfg_ready = 1'b1;
	assign in_stall  = valid_s1 ? (fifo_count > FIFO_CW'(FIFO_DEPTH - 4))
	                            : (fifo_count > FIFO_CW'(FIFO_DEPTH - 2));
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_cap_q  <= KEY_SIZE_RST;
			val_size_q <= VAL_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEY_SIZE: key_cap_q <= cfg_data[KEY_W-1:0];
				REG_VAL_SIZE: val_size_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && !in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_in;
			eol_s1  <= end_of_line;
		end
	end

	kvfs_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.char_s1  (char_s1),
		.eol_s1   (eol_s1),
		.key_cap  (key_cap_q),
		.val_size (val_size_q),
		.push     (push)
	);

	kvfs_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.not_empty (out_valid),
		.count     (fifo_count),
		.head      (head)
	);

	assign item_type = head.item_type;
	assign char_out  = head.ch;
	assign status    = head.status;
	assign final_res = head.final_res;

endmodule

// ----- rtl/core/kvfs_checker.sv -----
// Port-level checks for the key/value field splitter, bound to the top level.
// Depends on kvfs_pkg and key_value_field_splitter.
module kvfs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [1:0]                  item_type,
	input logic [kvfs_pkg::CHAR_W-1:0] char_out,
	input logic [1:0]                  status,
	input logic                        final_res
);
	import kvfs_pkg::*;

	a_final_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (final_res == (item_type == ITEM_STATUS)))
		else $error("final flag does not match a status request");

	a_byte_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && item_type != ITEM_STATUS) |-> (status == ST_OK))
		else $error("key or value byte carries a non-zero status");

	a_status_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && item_type == ITEM_STATUS) |-> (char_out == '0))
		else $error("status request carries a non-zero byte");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(item_type) && $stable(char_out)
		&& $stable(status)))
		else $error("stalled output request changed");

endmodule

bind key_value_field_splitter kvfs_checker u_kvfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.item_type (item_type),
	.char_out  (char_out),
	.status    (status),
	.final_res (final_res)
);

// ----- tb/sv/key_value_field_splitter_test.sv -----
// Self-checking testbench for the key/value field splitter: directed and random command lines.
// It predicts every result itself and compares results in order with random stalls on both sides.
// Depends on kvfs_pkg and key_value_field_splitter only.
`timescale 1ns / 1ps

module key_value_field_splitter_test;
	import kvfs_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned BYTES_PER_SETTING = 215;
	localparam int unsigned SETTINGS_TOTAL = 6;
	localparam int unsigned SETTLE_CYCLES = 6;

	class kv_split_scoreboard;
		kvfs_phase_t phase;
		logic [KEY_W-1:0] key_count;
		logic [KEY_W-1:0] key_cap;
		logic [VAL_W-1:0] value_count;
		logic [VAL_W-1:0] val_cap;
		logic newline_seen;
		logic key_overflow;
		kvfs_item_t due[$];
		int unsigned mismatches;
		int unsigned results_checked;
		int unsigned messages;
		int unsigned status_count[4];

		function new();
			key_cap = KEY_SIZE_RST;
			val_cap = VAL_SIZE_RST;
			mismatches = 0;
			results_checked = 0;
			messages = 0;
			foreach (status_count[i]) status_count[i] = 0;
			clear_message();
		endfunction

		function void clear_message();
			phase = PH_CMD;
			key_count = '0;
			value_count = '0;
			newline_seen = 1'b0;
			key_overflow = 1'b0;
		endfunction

		function void write_reg(kvfs_reg_t idx, logic [VAL_W-1:0] val);
			if (idx == REG_KEY_SIZE) begin
				key_cap = val[KEY_W-1:0];
			end else begin
				val_cap = val;
			end
		endfunction

		function void add(kvfs_item_type_t t, logic [CHAR_W-1:0] c, kvfs_status_t s, logic f);
			kvfs_item_t it;
			it.item_type = t;
			it.ch = c;
			it.status = s;
			it.final_res = f;
			due.push_back(it);
		endfunction

		function kvfs_status_t message_status();
			int unsigned vs;
			int unsigned vc;
			int unsigned len;
			vs = val_cap;
			vc = value_count;
			if (phase == PH_CMD || phase == PH_KEY) return ST_PARSE_ERR;
			if (key_overflow) return ST_KEY_LONG;
			if (phase == PH_GAP || phase == PH_QUOTED) return ST_PARSE_ERR;
			if (phase == PH_CLOSED) begin
				if (vc >= vs || vc >= VAL_LIMIT) return ST_VAL_LONG;
				return ST_OK;
			end
			len = (vc < vs) ? vc : vs;
			if ((vs > 0 && len >= vs - 1) || len >= VAL_LIMIT) return ST_VAL_LONG;
			return ST_OK;
		endfunction

		function void note_request(logic [CHAR_W-1:0] c, logic eol);
			case (phase)
				PH_CMD: begin
					if (c == CH_SPACE) phase = PH_KEY;
				end
				PH_KEY: begin
					if (c == CH_SPACE) begin
						key_overflow = (key_count >= key_cap) || (key_count >= KEY_LIMIT);
						phase = PH_GAP;
					end else begin
						add(ITEM_KEY, c, ST_OK, 1'b0);
						if (key_count != KEY_SAT) key_count++;
					end
				end
				PH_GAP: begin
					if (c == CH_QUOTE) begin
						phase = PH_QUOTED;
					end else if (c != CH_SPACE) begin
						phase = PH_UNQUOTED;
						value_count = 1;
						if (c == CH_NEWLINE) newline_seen = 1'b1;
						else add(ITEM_VALUE, c, ST_OK, 1'b0);
					end
				end
				PH_QUOTED: begin
					if (c == CH_QUOTE) begin
						phase = PH_CLOSED;
					end else begin
						add(ITEM_VALUE, c, ST_OK, 1'b0);
						if (value_count != VAL_SAT) value_count++;
					end
				end
				PH_UNQUOTED: begin
					if (value_count != VAL_SAT) value_count++;
					if (c == CH_NEWLINE) newline_seen = 1'b1;
					if (!newline_seen) add(ITEM_VALUE, c, ST_OK, 1'b0);
				end
				default: ;
			endcase
			if (eol) begin
				add(ITEM_STATUS, '0, message_status(), 1'b1);
				messages++;
				clear_message();
			end
		endfunction

		function void check_result(kvfs_item_t got);
			kvfs_item_t want;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: type %0d char %02h status %0d final %0b",
						got.item_type, got.ch, got.status, got.final_res);
				return;
			end
			want = due.pop_front();
			results_checked++;
			if (want.item_type == ITEM_STATUS) status_count[want.status]++;
			if (got.item_type !== want.item_type || got.ch !== want.ch ||
				got.status !== want.status || got.final_res !== want.final_res) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch at result %0d: expected type %0d char %02h ",
						"status %0d final %0b, got type %0d char %02h status %0d final %0b"},
						results_checked, want.item_type, want.ch, want.status, want.final_res,
						got.item_type, got.ch, got.status, got.final_res);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [CHAR_W-1:0] char_in;
	logic end_of_line;
	logic out_valid;
	logic out_stall;
	logic [1:0] item_type;
	logic [CHAR_W-1:0] char_out;
	logic [1:0] status;
	logic final_res;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [VAL_W-1:0] cfg_data;

	kv_split_scoreboard sb = new();
	bit in_idle;
	bit out_idle;
	int unsigned bytes_sent;
	int unsigned cycles;

	key_value_field_splitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_in(char_in),
		.end_of_line(end_of_line),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.item_type(item_type),
		.char_out(char_out),
		.status(status),
		.final_res(final_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_request(char_in, end_of_line);
			if (out_valid && !out_stall)
				sb.check_result(kvfs_item_t'({item_type, char_out, status, final_res}));
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycles, sb.due.size());
			$display("key_value_field_splitter test failed");
			$finish;
		end
	end

	initial begin
		int unsigned gap;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			gap = out_idle ? $urandom_range(0, 17) : 0;
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	function automatic logic [CHAR_W-1:0] pick_byte(input bit no_space, input bit no_quote);
		logic [CHAR_W-1:0] c;
		do begin
			case ($urandom_range(0, 9))
				0: c = CH_SPACE;
				1: c = CH_QUOTE;
				2: c = CH_NEWLINE;
				default: c = CHAR_W'($urandom_range(1, 255));
			endcase
		end while ((no_space && c == CH_SPACE) || (no_quote && c == CH_QUOTE));
		return c;
	endfunction

	function automatic int unsigned pick_len(input int unsigned edge_at, input int unsigned cap);
		int unsigned lo;
		int unsigned hi;
		if ($urandom_range(0, 9) < 8) return $urandom_range(0, 6);
		lo = (edge_at > 2) ? edge_at - 2 : 0;
		hi = (edge_at + 1 > cap) ? cap : edge_at + 1;
		return $urandom_range(lo, hi);
	endfunction

	task automatic send_byte(input logic [CHAR_W-1:0] c, input logic eol);
		int unsigned gap;
		gap = in_idle ? $urandom_range(0, 17) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		end_of_line <= eol;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_bytes(input logic [CHAR_W-1:0] msg[$]);
		foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
	endtask

	task automatic send_random_message();
		logic [CHAR_W-1:0] msg[$];
		int unsigned shape;
		int unsigned klen;
		int unsigned vlen;
		int unsigned n;
		int unsigned key_edge;
		int unsigned val_edge;
		key_edge = (sb.key_cap < KEY_LIMIT) ? sb.key_cap : KEY_LIMIT;
		val_edge = (sb.val_cap < VAL_LIMIT) ? sb.val_cap : VAL_LIMIT;
		shape = $urandom_range(0, 99);
		if (shape < 12) begin
			n = $urandom_range(1, 10);
			repeat (n) msg.push_back(pick_byte(1'b0, 1'b0));
		end else begin
			n = $urandom_range(0, 3);
			repeat (n) msg.push_back(pick_byte(1'b1, 1'b0));
			msg.push_back(CH_SPACE);
			klen = pick_len(key_edge, 70);
			repeat (klen) msg.push_back(pick_byte(1'b1, 1'b0));
			if (shape >= 16) begin
				msg.push_back(CH_SPACE);
				n = $urandom_range(0, 2);
				repeat (n) msg.push_back(CH_SPACE);
				if (shape >= 20) begin
					vlen = pick_len(val_edge, 260);
					if ($urandom_range(0, 1) == 1) begin
						msg.push_back(CH_QUOTE);
						repeat (vlen) msg.push_back(pick_byte(1'b0, 1'b1));
						if ($urandom_range(0, 9) != 0) begin
							msg.push_back(CH_QUOTE);
							n = $urandom_range(0, 2);
							repeat (n) msg.push_back(pick_byte(1'b0, 1'b0));
						end
					end else begin
						msg.push_back(pick_byte(1'b1, 1'b1));
						n = (vlen > 0) ? vlen - 1 : 0;
						repeat (n) msg.push_back(pick_byte(1'b0, 1'b0));
					end
				end
			end
		end
		send_bytes(msg);
	endtask

	task automatic write_reg(input kvfs_reg_t idx, input logic [VAL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, val);
	endtask

	// All requests must have been noted before the queue of expected results is trusted.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [CHAR_W-1:0] msg[$];
		int unsigned key_caps[SETTINGS_TOTAL];
		int unsigned val_caps[SETTINGS_TOTAL];
		int unsigned target;
		key_caps = '{64, 1, 256, 7, 0, 255};
		val_caps = '{256, 2, 4096, 3, 0, 4095};
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		char_in <= '0;
		end_of_line <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_KEY_SIZE;
		cfg_data <= '0;
		in_idle = 1'b1;
		out_idle = 1'b1;
		bytes_sent = 0;
		cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Quoted value followed by a stray byte after the closing quote.
		msg = '{8'h63, CH_SPACE, 8'h6b, CH_SPACE, CH_QUOTE, 8'h76, CH_QUOTE, 8'h7a};
		send_bytes(msg);
		// Line ends inside the command word.
		msg = '{8'h63};
		send_bytes(msg);
		// Extreme key bytes, then nothing but spaces where the value should be.
		msg = '{CH_SPACE, 8'hff, 8'h01, CH_SPACE, CH_SPACE};
		send_bytes(msg);
		// Unquoted value cut at a newline.
		msg = '{CH_SPACE, 8'h6b, CH_SPACE, 8'h76, CH_NEWLINE, 8'h7a};
		send_bytes(msg);
		// Quote opened and never closed.
		msg = '{CH_SPACE, 8'h6b, CH_SPACE, CH_QUOTE, CH_NEWLINE};
		send_bytes(msg);

		for (int unsigned s = 0; s < SETTINGS_TOTAL; s++) begin
			if (s != 0) begin
				drain();
				if (s == 4) begin
					key_caps[s] = $urandom_range(1, 256);
					val_caps[s] = $urandom_range(2, 4096);
				end
				write_reg(REG_KEY_SIZE, VAL_W'(key_caps[s]));
				write_reg(REG_VAL_SIZE, VAL_W'(val_caps[s]));
				cfg_valid <= 1'b0;
			end
			target = bytes_sent + BYTES_PER_SETTING;
			while (bytes_sent < target) begin
				if ($urandom_range(0, 7) == 0) in_idle = !in_idle;
				if ($urandom_range(0, 7) == 0) out_idle = !out_idle;
				send_random_message();
			end
		end

		drain();
		$display("Ran %0d messages (%0d bytes) over %0d size settings; %0d results checked.",
			sb.messages, bytes_sent, SETTINGS_TOTAL, sb.results_checked);
		$display("Final statuses: ok %0d, parse error %0d, key too long %0d, value too long %0d.",
			sb.status_count[ST_OK], sb.status_count[ST_PARSE_ERR],
			sb.status_count[ST_KEY_LONG], sb.status_count[ST_VAL_LONG]);
		if (sb.mismatches == 0 && sb.due.size() == 0) begin
			$display("key_value_field_splitter test passed");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("key_value_field_splitter test failed");
		end
		$finish;
	end
endmodule
